/* hdl/gcsm_pkg.sv */
// ----------------------------------------------------------------------------
// gcsm_pkg
// Shared types and codes for the ghost cell source mapper: transaction
// payloads, face kind codes, register indexes and the per-axis result.
// ----------------------------------------------------------------------------
package gcsm_pkg;

   // Field widths
   localparam int COORD_W  = 9;
   localparam int EXTENT_W = 10;
   localparam int GHOST_W  = 4;
   localparam int KINDS_W  = 6;
   localparam int INDEX_W  = 27;
   localparam int PLANE_W  = 2 * EXTENT_W;
   // Mapped coordinate: nonnegative results fit in 11 bits
   localparam int MAPPED_W = 11;
   // Signed working width for face arithmetic
   localparam int WORK_W   = 13;

   // Configuration port
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // Face kind codes; unlisted codes behave as periodic
   typedef enum logic [2:0] {
      KIND_PERIODIC = 3'd1,
      KIND_REFLECT  = 3'd2,
      KIND_TRANSMIT = 3'd3,
      KIND_CUSTOM   = 3'd4,
      KIND_EXCHANGE = 3'd5
   } face_kind_type;

   // Register indexes (byte address 4 * index)
   typedef enum logic [2:0] {
      REG_X_EXTENT    = 3'd0,
      REG_Y_EXTENT    = 3'd1,
      REG_Z_EXTENT    = 3'd2,
      REG_GHOST_WIDTH = 3'd3,
      REG_X_KINDS     = 3'd4,
      REG_Y_KINDS     = 3'd5,
      REG_Z_KINDS     = 3'd6
   } reg_index_type;

   // Reset values
   localparam logic [EXTENT_W-1:0] X_EXTENT_RST    = 10'd16;
   localparam logic [EXTENT_W-1:0] Y_EXTENT_RST    = 10'd1;
   localparam logic [EXTENT_W-1:0] Z_EXTENT_RST    = 10'd1;
   localparam logic [GHOST_W-1:0]  GHOST_WIDTH_RST = 4'd4;
   localparam logic [KINDS_W-1:0]  KINDS_RST       = 6'd9;
   localparam logic [PLANE_W-1:0]  PLANE_RST       = 20'd16;

   // Input transaction
   typedef struct packed {
      logic [COORD_W-1:0] cell_i;
      logic [COORD_W-1:0] cell_j;
      logic [COORD_W-1:0] cell_k;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic               source_valid;
      logic [INDEX_W-1:0] source_index;
      logic               flip_x;
      logic               flip_y;
      logic               flip_z;
   } rsp_type;

   // One axis after face mapping
   typedef struct packed {
      logic                ok;
      logic                flip;
      logic [MAPPED_W-1:0] coord;
   } axis_map_type;

endpackage

/* hdl/ghost_cell_source_mapper.sv */
// ----------------------------------------------------------------------------
// ghost_cell_source_mapper
// Returns the linear index of the real cell that fills a ghost cell of a
// padded 3-D grid, with a sign flag for each momentum component.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                        | payload
//  req     | in        | req_valid / req_stall            | req_data (req_type)
//  rsp     | out       | rsp_valid / rsp_stall            | rsp_data (rsp_type)
//  csr     | in        | psel, penable, pwrite, pready=1  | paddr, pwdata, prdata
//
// One transaction per cycle sustained while the result channel is not stalled.
// The path is an input register, three face mappers and a multiply-add into
// the result register; the plane size is a register refreshed every cycle.
// A stalled result holds, and one more transaction still enters the input
// register behind it. Synchronous reset clears both stages and loads the
// register defaults.
// ----------------------------------------------------------------------------
module ghost_cell_source_mapper
   import gcsm_pkg::*;
#(
   parameter int MAX_EXTENT = 512
)
(
   input  logic              clock,
   input  logic              reset,
   // input channel
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int EXT_MAX_CODE = (1 << EXTENT_W) - 1;
   localparam int CAP_INT = (MAX_EXTENT > EXT_MAX_CODE) ? EXT_MAX_CODE : MAX_EXTENT;
   localparam logic [EXTENT_W-1:0] EXT_CAP = EXTENT_W'(CAP_INT);

   logic [EXTENT_W-1:0] x_extent_ff;
   logic [EXTENT_W-1:0] y_extent_ff;
   logic [EXTENT_W-1:0] z_extent_ff;
   logic [GHOST_W-1:0]  ghost_width_ff;
   logic [KINDS_W-1:0]  x_kinds_ff;
   logic [KINDS_W-1:0]  y_kinds_ff;
   logic [KINDS_W-1:0]  z_kinds_ff;
   logic [PLANE_W-1:0]  plane_ff;

   logic                cfg_write;
   reg_index_type       cfg_index;
   logic [EXTENT_W-1:0] extent_in;

   logic                stage_valid_ff;
   req_type             stage_data_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;
   logic                advance;
   logic                load_stage;

   axis_map_type        map_x;
   axis_map_type        map_y;
   axis_map_type        map_z;
   logic [2*EXTENT_W:0] prod_y;
   logic [PLANE_W+MAPPED_W-1:0] prod_z;
   logic [INDEX_W-1:0]  index_sum;

   // Configuration decode
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = reg_index_type'(paddr[4:2]);
   assign extent_in = (pwdata[EXTENT_W-1:0] > EXT_CAP) ? EXT_CAP : pwdata[EXTENT_W-1:0];

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_extent_ff    <= X_EXTENT_RST;
         y_extent_ff    <= Y_EXTENT_RST;
         z_extent_ff    <= Z_EXTENT_RST;
         ghost_width_ff <= GHOST_WIDTH_RST;
         x_kinds_ff     <= KINDS_RST;
         y_kinds_ff     <= KINDS_RST;
         z_kinds_ff     <= KINDS_RST;
         plane_ff       <= PLANE_RST;
      end else begin
         plane_ff <= x_extent_ff * y_extent_ff;
         if (cfg_write) begin
            case (cfg_index)
               REG_X_EXTENT:    x_extent_ff    <= extent_in;
               REG_Y_EXTENT:    y_extent_ff    <= extent_in;
               REG_Z_EXTENT:    z_extent_ff    <= extent_in;
               REG_GHOST_WIDTH: ghost_width_ff <= pwdata[GHOST_W-1:0];
               REG_X_KINDS:     x_kinds_ff     <= pwdata[KINDS_W-1:0];
               REG_Y_KINDS:     y_kinds_ff     <= pwdata[KINDS_W-1:0];
               REG_Z_KINDS:     z_kinds_ff     <= pwdata[KINDS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Read back
   always_comb begin
      case (cfg_index)
         REG_X_EXTENT:    prdata = DATA_W'(x_extent_ff);
         REG_Y_EXTENT:    prdata = DATA_W'(y_extent_ff);
         REG_Z_EXTENT:    prdata = DATA_W'(z_extent_ff);
         REG_GHOST_WIDTH: prdata = DATA_W'(ghost_width_ff);
         REG_X_KINDS:     prdata = DATA_W'(x_kinds_ff);
         REG_Y_KINDS:     prdata = DATA_W'(y_kinds_ff);
         REG_Z_KINDS:     prdata = DATA_W'(z_kinds_ff);
         default:         prdata = '0;
      endcase
   end

   // Pipeline flow: the result register advances unless it holds a stalled result
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign load_stage = !stage_valid_ff || advance;
   assign req_stall  = !load_stage;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (load_stage) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_stage && req_valid) begin
         stage_data_ff <= req_data;
      end
   end

   // Map each axis
   gcsm_axis u_axis_x (
      .coord  (stage_data_ff.cell_i),
      .extent (x_extent_ff),
      .ghost  (ghost_width_ff),
      .kinds  (x_kinds_ff),
      .result (map_x)
   );

   gcsm_axis u_axis_y (
      .coord  (stage_data_ff.cell_j),
      .extent (y_extent_ff),
      .ghost  (ghost_width_ff),
      .kinds  (y_kinds_ff),
      .result (map_y)
   );

   gcsm_axis u_axis_z (
      .coord  (stage_data_ff.cell_k),
      .extent (z_extent_ff),
      .ghost  (ghost_width_ff),
      .kinds  (z_kinds_ff),
      .result (map_z)
   );

   // Form the linear index, wrapped to the index width
   assign prod_y    = x_extent_ff * map_y.coord;
   assign prod_z    = plane_ff * map_z.coord;
   assign index_sum = INDEX_W'(map_x.coord) + INDEX_W'(prod_y) + prod_z[INDEX_W-1:0];

   // Build the result; a missing source zeroes every field
   always_comb begin
      rsp_data_in = '0;
      if (map_x.ok && map_y.ok && map_z.ok) begin
         rsp_data_in.source_valid = 1'b1;
         rsp_data_in.source_index = index_sum;
         rsp_data_in.flip_x       = map_x.flip;
         rsp_data_in.flip_y       = map_y.flip;
         rsp_data_in.flip_z       = map_z.flip;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/gcsm_axis.sv */
// ----------------------------------------------------------------------------
// gcsm_axis
// Maps one coordinate of a ghost cell to its source coordinate on that axis,
// applying the lower or upper face rule and raising the reflect flag.
// ----------------------------------------------------------------------------
module gcsm_axis
   import gcsm_pkg::*;
(
   input  logic [COORD_W-1:0]  coord,
   input  logic [EXTENT_W-1:0] extent,
   input  logic [GHOST_W-1:0]  ghost,
   input  logic [KINDS_W-1:0]  kinds,
   output axis_map_type        result
);

   logic signed [WORK_W-1:0] c_s;
   logic signed [WORK_W-1:0] n_s;
   logic signed [WORK_W-1:0] g_s;
   logic signed [WORK_W-1:0] inner_s;
   logic signed [WORK_W-1:0] r_s;
   logic                     enabled;
   logic                     lower;
   logic                     upper;
   logic                     flip;
   face_kind_type            kind;

   // Extend operands into a signed working width
   assign c_s     = signed'({{(WORK_W-COORD_W){1'b0}}, coord});
   assign n_s     = signed'({{(WORK_W-EXTENT_W){1'b0}}, extent});
   assign g_s     = signed'({{(WORK_W-GHOST_W){1'b0}}, ghost});
   assign inner_s = n_s - g_s;

   // Classify the coordinate; the lower face wins where both regions meet
   assign enabled = extent > EXTENT_W'(1);
   assign lower   = c_s < g_s;
   assign upper   = !lower && (c_s >= inner_s);
   assign kind    = face_kind_type'(lower ? kinds[2:0] : kinds[5:3]);

   // Apply the face rule
   always_comb begin
      flip = 1'b0;
      r_s  = c_s;
      if (lower || upper) begin
         case (kind)
            KIND_REFLECT: begin
               flip = 1'b1;
               r_s  = upper ? (WORK_W'(2) * inner_s - c_s - WORK_W'(1))
                            : (WORK_W'(2) * g_s - c_s - WORK_W'(1));
            end
            KIND_TRANSMIT: begin
               r_s = upper ? (inner_s - WORK_W'(1)) : g_s;
            end
            KIND_CUSTOM: begin
               r_s = -WORK_W'(1);
            end
            KIND_EXCHANGE: begin
               r_s = c_s;
            end
            default: begin
               r_s = upper ? (c_s - n_s + WORK_W'(2) * g_s)
                           : (c_s + n_s - WORK_W'(2) * g_s);
            end
         endcase
      end
   end

   // A disabled axis contributes zero; a negative result has no source
   always_comb begin
      if (!enabled) begin
         result.ok    = 1'b1;
         result.flip  = 1'b0;
         result.coord = '0;
      end else begin
         result.ok    = !r_s[WORK_W-1];
         result.flip  = flip;
         result.coord = r_s[MAPPED_W-1:0];
      end
   end

endmodule

/* tb/sv/tb_ghost_cell_source_mapper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ghost_cell_source_mapper
// Self-checking bench for the ghost cell source mapper. A table of directed
// transactions walks the face kinds and corner cases, then random phases
// reprogram the grid over the register port and stream random coordinates.
// Every result is compared field by field against a fixed expectation or a
// local source predictor, and every write to a mapped register is read back.
// ----------------------------------------------------------------------------
module tb_ghost_cell_source_mapper;
   import gcsm_pkg::*;

   localparam int          MAX_EXTENT    = 512;
   localparam int          RANDOM_PHASES = 30;
   localparam int          PHASE_CELLS   = 40;
   localparam int          IDLE_PERCENT  = 36;
   // Register slot past the end of the map; writes there must be ignored
   localparam logic [2:0]  REG_UNUSED    = 3'd7;
   // Unlisted kind codes that fall back to periodic
   localparam logic [2:0]  KIND_ALIAS_LO = 3'd0;
   localparam logic [2:0]  KIND_ALIAS_HI = 3'd7;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_KNOWN,
      ROW_PREDICT
   } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [2:0]        reg_idx;
      logic [DATA_W-1:0] reg_val;
      req_type           site;
      rsp_type           known;
   } plan_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // Local copy of the register file
   logic [EXTENT_W-1:0] cfg_x_extent    = X_EXTENT_RST;
   logic [EXTENT_W-1:0] cfg_y_extent    = Y_EXTENT_RST;
   logic [EXTENT_W-1:0] cfg_z_extent    = Z_EXTENT_RST;
   logic [GHOST_W-1:0]  cfg_ghost_width = GHOST_WIDTH_RST;
   logic [KINDS_W-1:0]  cfg_x_kinds     = KINDS_RST;
   logic [KINDS_W-1:0]  cfg_y_kinds     = KINDS_RST;
   logic [KINDS_W-1:0]  cfg_z_kinds     = KINDS_RST;

   rsp_type      expected_sources[$];
   plan_row_type plan[$];
   int           mismatch_count = 0;
   bit           calm = 1'b0;

   ghost_cell_source_mapper i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_ghost_cell_source_mapper: done, errors");
      $finish;
   end

   // Map one axis coordinate through its face rules; -1 means no source
   function automatic int mapped_coord(input int c, input int n,
                                       input logic [KINDS_W-1:0] kinds,
                                       output bit flip);
      int            g;
      bit            upper;
      face_kind_type kind;
      g    = int'(cfg_ghost_width);
      flip = 1'b0;
      if (n <= 1) return 0;
      if (c >= g && c < n - g) return c;
      // lower face wins where both regions overlap
      upper = (c >= g);
      kind  = face_kind_type'(upper ? kinds[5:3] : kinds[2:0]);
      case (kind)
         KIND_REFLECT: begin
            flip = 1'b1;
            return upper ? 2 * (n - g) - c - 1 : 2 * g - c - 1;
         end
         KIND_TRANSMIT: return upper ? n - g - 1 : g;
         KIND_CUSTOM:   return -1;
         KIND_EXCHANGE: return c;
         default:       return upper ? c - n + 2 * g : c + n - 2 * g;
      endcase
   endfunction

   // Predict the source cell and momentum flips for one ghost coordinate
   function automatic rsp_type source_of_cell(input req_type site);
      rsp_type res;
      int      ir, jr, kr;
      bit      fx, fy, fz;
      longint  sum;
      res = '0;
      ir  = mapped_coord(int'(site.cell_i), int'(cfg_x_extent), cfg_x_kinds, fx);
      jr  = mapped_coord(int'(site.cell_j), int'(cfg_y_extent), cfg_y_kinds, fy);
      kr  = mapped_coord(int'(site.cell_k), int'(cfg_z_extent), cfg_z_kinds, fz);
      if (ir < 0 || jr < 0 || kr < 0) return res;
      sum = longint'(ir) + longint'(cfg_x_extent) * longint'(jr)
          + longint'(cfg_x_extent) * longint'(cfg_y_extent) * longint'(kr);
      res.source_valid = 1'b1;
      res.source_index = sum[INDEX_W-1:0];
      res.flip_x       = fx;
      res.flip_y       = fy;
      res.flip_z       = fz;
      return res;
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord(input logic [EXTENT_W-1:0] extent);
      if (extent > 1 && $urandom_range(0, 9) < 8)
         return COORD_W'($urandom_range(0, int'(extent) - 1));
      return COORD_W'($urandom_range(0, 511));
   endfunction

   function automatic logic [DATA_W-1:0] pick_extent();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return DATA_W'($urandom_range(0, 1));
      if (r == 1) return DATA_W'(MAX_EXTENT);
      if (r == 2) return DATA_W'($urandom_range(MAX_EXTENT + 1, 1023));
      return DATA_W'($urandom_range(2, 40));
   endfunction

   task automatic add_csr(input logic [2:0] idx, input logic [DATA_W-1:0] val);
      plan_row_type row;
      row         = '{kind: ROW_CSR, default: '0};
      row.reg_idx = idx;
      row.reg_val = val;
      plan.push_back(row);
   endtask

   task automatic add_cell(input int i, input int j, input int k, input bit has_known,
                           input rsp_type known);
      plan_row_type row;
      row             = '{kind: ROW_PREDICT, default: '0};
      row.kind        = has_known ? ROW_KNOWN : ROW_PREDICT;
      row.site.cell_i = COORD_W'(i);
      row.site.cell_j = COORD_W'(j);
      row.site.cell_k = COORD_W'(k);
      row.known       = known;
      plan.push_back(row);
   endtask

   // One register port access, setup phase then access phase; returns the read data of the access phase
   task automatic csr_access(input bit is_write, input logic [2:0] idx,
                             input logic [DATA_W-1:0] wval,
                             output logic [DATA_W-1:0] rval);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wval;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rval = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write a register, mirror it locally and read it back; an unmapped slot is only written
   task automatic csr_set(input logic [2:0] idx, input logic [DATA_W-1:0] val);
      logic [DATA_W-1:0]   got;
      logic [DATA_W-1:0]   stored;
      logic [EXTENT_W-1:0] ext;
      ext = val[EXTENT_W-1:0];
      if (ext > MAX_EXTENT) ext = EXTENT_W'(MAX_EXTENT);
      stored = '0;
      csr_access(1'b1, idx, val, got);
      case (idx)
         REG_X_EXTENT:    begin cfg_x_extent = ext; stored = DATA_W'(ext); end
         REG_Y_EXTENT:    begin cfg_y_extent = ext; stored = DATA_W'(ext); end
         REG_Z_EXTENT:    begin cfg_z_extent = ext; stored = DATA_W'(ext); end
         REG_GHOST_WIDTH: begin
            cfg_ghost_width = val[GHOST_W-1:0];
            stored          = DATA_W'(val[GHOST_W-1:0]);
         end
         REG_X_KINDS: begin
            cfg_x_kinds = val[KINDS_W-1:0];
            stored      = DATA_W'(val[KINDS_W-1:0]);
         end
         REG_Y_KINDS: begin
            cfg_y_kinds = val[KINDS_W-1:0];
            stored      = DATA_W'(val[KINDS_W-1:0]);
         end
         REG_Z_KINDS: begin
            cfg_z_kinds = val[KINDS_W-1:0];
            stored      = DATA_W'(val[KINDS_W-1:0]);
         end
         default:         return;
      endcase
      csr_access(1'b0, idx, '0, got);
      if (got !== stored) begin
         $display("%0t: register %0d readback expected %0h actual %0h",
                  $time, idx, stored, got);
         mismatch_count++;
      end
   endtask

   // Offer one transaction with random idle cycles outside the calm stretch; log its expectation on accept
   task automatic push_cell(input req_type site, input rsp_type want);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= site;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_sources.push_back(want);
   endtask

   // Drop valid, drain all results and let the pipeline settle
   task automatic quiesce();
      req_valid <= 1'b0;
      while (expected_sources.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic report_field(input string name, input logic [INDEX_W-1:0] want,
                               input logic [INDEX_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Stall the result side at random, except during the calm stretch
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sources.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_sources.pop_front();
            report_field("source_valid", INDEX_W'(want.source_valid),
                         INDEX_W'(rsp_data.source_valid));
            report_field("source_index", want.source_index, rsp_data.source_index);
            report_field("flip_x", INDEX_W'(want.flip_x), INDEX_W'(rsp_data.flip_x));
            report_field("flip_y", INDEX_W'(want.flip_y), INDEX_W'(rsp_data.flip_y));
            report_field("flip_z", INDEX_W'(want.flip_z), INDEX_W'(rsp_data.flip_z));
         end
      end
   end

   initial begin
      req_type           site;
      logic [DATA_W-1:0] ext_val[3];
      logic [DATA_W-1:0] ghost_val;
      logic [DATA_W-1:0] kinds_val[3];

      // Directed plan: defaults first (x extent 16, ghost 4, all periodic)
      add_cell(0, 0, 0, 1'b1, rsp_type'{1'b1, 27'd8, 1'b0, 1'b0, 1'b0});
      add_cell(3, 0, 0, 1'b1, rsp_type'{1'b1, 27'd11, 1'b0, 1'b0, 1'b0});
      add_cell(4, 0, 0, 1'b1, rsp_type'{1'b1, 27'd4, 1'b0, 1'b0, 1'b0});
      add_cell(15, 0, 0, 1'b1, rsp_type'{1'b1, 27'd7, 1'b0, 1'b0, 1'b0});
      add_cell(7, 511, 511, 1'b1, rsp_type'{1'b1, 27'd7, 1'b0, 1'b0, 1'b0});
      add_cell(511, 0, 0, 1'b1, rsp_type'{1'b1, 27'd503, 1'b0, 1'b0, 1'b0});
      // reflect below, transmit above
      add_csr(REG_X_KINDS, DATA_W'({KIND_TRANSMIT, KIND_REFLECT}));
      add_cell(0, 0, 0, 1'b1, rsp_type'{1'b1, 27'd7, 1'b1, 1'b0, 1'b0});
      add_cell(15, 0, 0, 1'b1, rsp_type'{1'b1, 27'd11, 1'b0, 1'b0, 1'b0});
      // custom below, exchange above
      add_csr(REG_X_KINDS, DATA_W'({KIND_EXCHANGE, KIND_CUSTOM}));
      add_cell(1, 0, 0, 1'b1, rsp_type'{1'b0, 27'd0, 1'b0, 1'b0, 1'b0});
      add_cell(14, 0, 0, 1'b1, rsp_type'{1'b1, 27'd14, 1'b0, 1'b0, 1'b0});
      // overlapping face regions on y, clamped z extent, alias kind codes on x
      add_csr(REG_Y_EXTENT, 32'd6);
      add_csr(REG_Y_KINDS, DATA_W'({KIND_REFLECT, KIND_REFLECT}));
      add_csr(REG_Z_EXTENT, 32'd1000);
      add_csr(REG_X_KINDS, DATA_W'({KIND_ALIAS_LO, KIND_ALIAS_HI}));
      add_cell(0, 3, 0, 1'b0, '0);
      add_cell(5, 5, 0, 1'b0, '0);
      add_cell(10, 2, 511, 1'b0, '0);
      add_cell(2, 0, 300, 1'b0, '0);
      // empty lower region, x axis disabled by extent zero
      add_csr(REG_GHOST_WIDTH, 32'd0);
      add_csr(REG_X_EXTENT, 32'd0);
      add_cell(0, 0, 0, 1'b0, '0);
      add_cell(511, 511, 511, 1'b0, '0);
      add_cell(0, 5, 3, 1'b0, '0);
      // widest grid and ghost width, index past 27 bits
      add_csr(REG_GHOST_WIDTH, 32'd15);
      add_csr(REG_X_EXTENT, 32'd512);
      add_csr(REG_Y_EXTENT, 32'd512);
      add_csr(REG_Z_EXTENT, 32'd2);
      add_csr(REG_X_KINDS, DATA_W'({KIND_TRANSMIT, KIND_REFLECT}));
      add_csr(REG_Y_KINDS, DATA_W'({KIND_EXCHANGE, KIND_EXCHANGE}));
      add_csr(REG_Z_KINDS, DATA_W'({KIND_PERIODIC, KIND_PERIODIC}));
      add_cell(511, 511, 511, 1'b0, '0);
      add_cell(0, 0, 0, 1'b0, '0);
      add_cell(256, 300, 1, 1'b0, '0);
      // write past the register map, then a single ghost layer
      add_csr(REG_UNUSED, 32'hFFFF_FFFF);
      add_csr(REG_GHOST_WIDTH, 32'd1);
      add_cell(0, 0, 0, 1'b0, '0);
      add_cell(511, 511, 0, 1'b0, '0);

      // Hold reset, then release it
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed plan
      foreach (plan[n]) begin
         case (plan[n].kind)
            ROW_CSR: begin
               quiesce();
               csr_set(plan[n].reg_idx, plan[n].reg_val);
            end
            ROW_KNOWN: push_cell(plan[n].site, plan[n].known);
            default:   push_cell(plan[n].site, source_of_cell(plan[n].site));
         endcase
      end

      // Random phases: reprogram the grid, then stream coordinates
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            ext_val   = '{32'd1023, 32'd1023, 32'd1023};
            ghost_val = 32'd15;
            kinds_val = '{32'd63, 32'd63, 32'd63};
         end else if (p == 1) begin
            ext_val   = '{32'd0, 32'd0, 32'd0};
            ghost_val = 32'd0;
            kinds_val = '{32'd0, 32'd0, 32'd0};
         end else begin
            foreach (ext_val[a]) begin
               ext_val[a]   = pick_extent();
               kinds_val[a] = DATA_W'($urandom());
            end
            ghost_val = ($urandom_range(0, 9) < 2) ? DATA_W'($urandom())
                                                    : DATA_W'($urandom_range(1, 8));
         end
         quiesce();
         calm = (p >= 12 && p < 16);
         csr_set(REG_X_EXTENT, ext_val[0]);
         csr_set(REG_Y_EXTENT, ext_val[1]);
         csr_set(REG_Z_EXTENT, ext_val[2]);
         csr_set(REG_GHOST_WIDTH, ghost_val);
         csr_set(REG_X_KINDS, kinds_val[0]);
         csr_set(REG_Y_KINDS, kinds_val[1]);
         csr_set(REG_Z_KINDS, kinds_val[2]);
         if (p % 5 == 4) csr_set(REG_UNUSED, $urandom());
         for (int n = 0; n < PHASE_CELLS; n++) begin
            site.cell_i = pick_coord(cfg_x_extent);
            site.cell_j = pick_coord(cfg_y_extent);
            site.cell_k = pick_coord(cfg_z_extent);
            push_cell(site, source_of_cell(site));
         end
      end

      // Drain and report
      quiesce();
      calm = 1'b0;
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_ghost_cell_source_mapper: done, clean");
      end else begin
         $display("tb_ghost_cell_source_mapper: done, errors");
      end
      $finish;
   end

endmodule
